// ----- src/escp_pkg.sv -----
// ----------------------------------------------------------------------------
// escp_pkg: shared types and constants of the edit span conflict planner
// Item formats for both channels, cell contents and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package escp_pkg;

  localparam int MAX_SPANS_DEF = 32;
  localparam int OFFSET_BITS   = 32;
  localparam int TAG_BITS      = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [TAG_BITS-1:0]    tag_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_OVERLAP  = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  typedef struct packed {
    offset_t primary_start;
    offset_t primary_end;
    logic    primary_resolved;
    tag_t    primary_tag;
    logic    fallback_usable;
    offset_t fallback_start;
    offset_t fallback_end;
    tag_t    fallback_tag;
    logic    last_span;
  } in_item_t;

  typedef struct packed {
    offset_t    span_start;
    offset_t    span_end;
    tag_t       span_tag;
    logic       used_fallback;
    logic [1:0] status;
    logic       last_result;
  } out_item_t;

  // one collected span as held in the sort chain
  typedef struct packed {
    offset_t lo;
    offset_t hi;
    tag_t    tag;
    logic    fb_ok;
    offset_t fb_lo;
    offset_t fb_hi;
    tag_t    fb_tag;
  } entry_t;

  // one kept span as held in the plan chain
  typedef struct packed {
    offset_t lo;
    offset_t hi;
    tag_t    tag;
  } plan_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clear;
  } sort_ctrl_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } plan_ctrl_t;

endpackage

`default_nettype wire

// ----- src/edit_span_conflict_planner_core.sv -----
// ----------------------------------------------------------------------------
// edit_span_conflict_planner_core: plans a set of edit spans
// Spans go into a sorted cell chain as they arrive; after the last span the
// chain is swept into a plan chain, which is then emitted in start order.
// ----------------------------------------------------------------------------
// Usage:
//   span channel (span_valid / span_stall / span): one edit span per item.
//   Spans are taken one per cycle while the block is collecting and no result
//   is stalled; each is placed in order of start by the sort chain in the
//   cycle it arrives. The item with last_span set closes the set. If the set
//   already failed (missing offsets, too many spans) one error result follows
//   at once. Otherwise the sweep takes the stored spans one at a time from the
//   head of the sort chain into the plan chain, which then shifts up towards
//   the output past the empty cells above the plan (MAX_SPANS minus the
//   planned count) and emits the planned spans, one per cycle while the result
//   channel does not stall. A sweep failure gives one error result instead.
//   result channel (result_valid / result_stall / result): registered; a
//   stalled result holds, and the emission pauses behind it. No span is
//   taken while a plan is swept or emitted.
//   Reset empties both chains and the error state; stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_span_conflict_planner_core #(
  parameter int MAX_SPANS = escp_pkg::MAX_SPANS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  span_valid,
  output logic                 span_stall,
  input  escp_pkg::in_item_t   span,
  output logic                 result_valid,
  input  wire                  result_stall,
  output escp_pkg::out_item_t  result
);
  import escp_pkg::*;

  localparam int CW = $clog2(MAX_SPANS + 1);

  typedef enum logic [1:0] {S_LOAD, S_SWEEP, S_EMIT} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] remaining;
  logic          fallback_taken;
  logic [1:0]    error_code;
  offset_t       error_position;

  entry_t               sort_q [MAX_SPANS];
  logic [MAX_SPANS-1:0] sort_v;
  logic [MAX_SPANS-1:0] sort_gt;
  plan_t                plan_q [MAX_SPANS];
  logic [MAX_SPANS-1:0] plan_v;

  sort_ctrl_t sort_ctrl;
  plan_ctrl_t plan_ctrl;
  plan_ctrl_t plan_ctrl0;

  logic   out_free;
  logic   accept;
  logic   full;
  logic   use_fb;
  logic   ins_ok;
  logic [1:0] code_now;
  offset_t    pos_now;
  entry_t new_entry;

  assign out_free   = !result_valid || !result_stall;
  assign span_stall = !((state == S_LOAD) && out_free);
  assign accept     = span_valid && !span_stall;
  assign full       = (count == CW'(MAX_SPANS));
  assign use_fb     = !span.primary_resolved && span.fallback_usable;
  assign ins_ok     = accept && !full;

  always_comb begin
    new_entry.lo     = use_fb ? span.fallback_start : span.primary_start;
    new_entry.hi     = use_fb ? span.fallback_end   : span.primary_end;
    new_entry.tag    = use_fb ? span.fallback_tag   : span.primary_tag;
    new_entry.fb_ok  = span.fallback_usable && !use_fb;
    new_entry.fb_lo  = span.fallback_start;
    new_entry.fb_hi  = span.fallback_end;
    new_entry.fb_tag = span.fallback_tag;
  end

  // error state after this item; too many spans overrides missing offsets
  always_comb begin
    code_now = error_code;
    pos_now  = error_position;
    if (full) begin
      if (error_code != ST_TOO_MANY) begin
        code_now = ST_TOO_MANY;
        pos_now  = span.primary_start;
      end
    end else if (!span.primary_resolved && !span.fallback_usable &&
                 (error_code == ST_OK)) begin
      code_now = ST_MISSING;
      pos_now  = span.primary_start;
    end
  end

  // sweep decision on the head of the sort chain
  entry_t  head;
  plan_t   kept;
  logic    kept_v;
  logic    prior_v;
  offset_t prior_hi;
  logic    overlap;
  logic    fb_fit;
  logic    sweep_step;
  logic    sweep_push;
  logic    sweep_repl;
  logic    sweep_fail;
  logic    emit_step;
  logic    emit_load;
  logic    load_clear;

  assign head   = sort_q[0];
  assign kept   = plan_q[0];
  assign kept_v = plan_v[0];

  generate
    if (MAX_SPANS > 1) begin : g_prior
      assign prior_v  = plan_v[1];
      assign prior_hi = plan_q[1].hi;
    end else begin : g_no_prior
      assign prior_v  = 1'b0;
      assign prior_hi = '0;
    end
  endgenerate

  assign overlap = kept_v && (kept.lo < head.hi) && (head.lo < kept.hi);
  assign fb_fit  = head.fb_ok && (head.fb_lo <= kept.lo) && (head.fb_hi >= kept.hi) &&
                   (head.fb_hi >= head.hi) && (!prior_v || (prior_hi <= head.fb_lo));

  assign sweep_step = (state == S_SWEEP) && sort_v[0] && out_free;
  assign sweep_push = sweep_step && !overlap;
  assign sweep_repl = sweep_step && overlap && fb_fit;
  assign sweep_fail = sweep_step && overlap && !fb_fit;

  // top cell not yet filled: keep shifting; filled: shift as it is emitted
  assign emit_load = (state == S_EMIT) && plan_v[MAX_SPANS-1] && out_free;
  assign emit_step = (state == S_EMIT) && (!plan_v[MAX_SPANS-1] || out_free);

  assign load_clear = accept && span.last_span && (code_now != ST_OK);

  always_comb begin
    sort_ctrl.ins   = ins_ok;
    sort_ctrl.shift = sweep_push || sweep_repl;
    sort_ctrl.clear = load_clear || sweep_fail;
    plan_ctrl.shift  = sweep_push || emit_step;
    plan_ctrl.clear  = sweep_fail;
    plan_ctrl0.shift = sweep_push || sweep_repl || emit_step;
    plan_ctrl0.clear = sweep_fail;
  end

  plan_t plan_in;
  logic  plan_in_v;

  always_comb begin
    plan_in   = '0;
    plan_in_v = 1'b0;
    if (state == S_SWEEP) begin
      plan_in_v = 1'b1;
      if (overlap) begin
        plan_in.lo  = head.fb_lo;
        plan_in.hi  = head.fb_hi;
        plan_in.tag = head.fb_tag;
      end else begin
        plan_in.lo  = head.lo;
        plan_in.hi  = head.hi;
        plan_in.tag = head.tag;
      end
    end
  end

  generate
    for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
      entry_t     s_prev;
      logic       s_prev_v;
      logic       s_prev_gt;
      entry_t     s_next;
      logic       s_next_v;
      plan_t      p_prev;
      logic       p_prev_v;
      plan_ctrl_t p_ctrl;

      if (i == 0) begin : g_first
        assign s_prev    = '0;
        assign s_prev_v  = 1'b1;
        assign s_prev_gt = 1'b0;
        assign p_prev    = plan_in;
        assign p_prev_v  = plan_in_v;
        assign p_ctrl    = plan_ctrl0;
      end else begin : g_inner
        assign s_prev    = sort_q[i-1];
        assign s_prev_v  = sort_v[i-1];
        assign s_prev_gt = sort_gt[i-1];
        assign p_prev    = plan_q[i-1];
        assign p_prev_v  = plan_v[i-1];
        assign p_ctrl    = plan_ctrl;
      end

      if (i == MAX_SPANS - 1) begin : g_top
        assign s_next   = '0;
        assign s_next_v = 1'b0;
      end else begin : g_below
        assign s_next   = sort_q[i+1];
        assign s_next_v = sort_v[i+1];
      end

      escp_sort_cell u_sort (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (sort_ctrl),
        .new_entry  (new_entry),
        .prev_entry (s_prev),
        .prev_valid (s_prev_v),
        .prev_gt    (s_prev_gt),
        .next_entry (s_next),
        .next_valid (s_next_v),
        .entry      (sort_q[i]),
        .valid      (sort_v[i]),
        .gt         (sort_gt[i])
      );

      escp_plan_cell u_plan (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (p_ctrl),
        .prev_span  (p_prev),
        .prev_valid (p_prev_v),
        .span       (plan_q[i]),
        .valid      (plan_v[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      count          <= '0;
      remaining      <= '0;
      fallback_taken <= 1'b0;
      error_code     <= ST_OK;
      error_position <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            error_code     <= code_now;
            error_position <= pos_now;
            if (!full) begin
              count <= count + 1'b1;
            end
            if (use_fb && !full) begin
              fallback_taken <= 1'b1;
            end
            if (span.last_span) begin
              count <= '0;
              if (code_now != ST_OK) begin
                result_valid   <= 1'b1;
                result         <= '{span_start: pos_now, span_end: '0, span_tag: '0,
                                    used_fallback: 1'b0, status: code_now,
                                    last_result: 1'b1};
                fallback_taken <= 1'b0;
                error_code     <= ST_OK;
                error_position <= '0;
              end else begin
                remaining <= '0;
                state     <= S_SWEEP;
              end
            end
          end
        end
        S_SWEEP: begin
          if (!sort_v[0]) begin
            state <= S_EMIT;
          end else if (sweep_fail) begin
            result_valid   <= 1'b1;
            result         <= '{span_start: head.lo, span_end: '0, span_tag: '0,
                                used_fallback: 1'b0, status: ST_OVERLAP,
                                last_result: 1'b1};
            fallback_taken <= 1'b0;
            state          <= S_LOAD;
          end else if (sweep_repl) begin
            fallback_taken <= 1'b1;
          end else if (sweep_push) begin
            remaining <= remaining + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            result_valid <= 1'b1;
            result       <= '{span_start: plan_q[MAX_SPANS-1].lo,
                              span_end: plan_q[MAX_SPANS-1].hi,
                              span_tag: plan_q[MAX_SPANS-1].tag,
                              used_fallback: fallback_taken, status: ST_OK,
                              last_result: (remaining == CW'(1))};
            remaining    <= remaining - 1'b1;
            if (remaining == CW'(1)) begin
              fallback_taken <= 1'b0;
              state          <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/escp_sort_cell.sv -----
// ----------------------------------------------------------------------------
// escp_sort_cell: one cell of the insertion sort chain
// Holds one entry; on insert it keeps, takes the new entry or takes its lower
// neighbour; on sweep it takes its upper neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module escp_sort_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  escp_pkg::sort_ctrl_t   ctrl,
  input  escp_pkg::entry_t       new_entry,
  input  escp_pkg::entry_t       prev_entry,
  input  wire                    prev_valid,
  input  wire                    prev_gt,
  input  escp_pkg::entry_t       next_entry,
  input  wire                    next_valid,
  output escp_pkg::entry_t       entry,
  output logic                   valid,
  output logic                   gt
);
  import escp_pkg::*;

  entry_t entry_next;
  logic   valid_next;

  // strict compare keeps equal starts in arrival order
  assign gt = valid && (new_entry.lo < entry.lo);

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    priority if (ctrl.clear) begin
      valid_next = 1'b0;
    end else if (ctrl.ins) begin
      priority if (prev_gt) begin
        entry_next = prev_entry;
        valid_next = 1'b1;
      end else if (gt || (!valid && prev_valid)) begin
        entry_next = new_entry;
        valid_next = 1'b1;
      end else begin
        valid_next = valid;
      end
    end else if (ctrl.shift) begin
      entry_next = next_entry;
      valid_next = next_valid;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ----- src/escp_plan_cell.sv -----
// ----------------------------------------------------------------------------
// escp_plan_cell: one cell of the plan chain
// Holds one kept span; shifts it up the chain on push or on emission.
// ----------------------------------------------------------------------------
`default_nettype none

module escp_plan_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  escp_pkg::plan_ctrl_t  ctrl,
  input  escp_pkg::plan_t       prev_span,
  input  wire                   prev_valid,
  output escp_pkg::plan_t       span,
  output logic                  valid
);
  import escp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      span <= prev_span;
    end
  end

endmodule

`default_nettype wire

// ----- src/escp_checker.sv -----
// ----------------------------------------------------------------------------
// escp_checker: port-level checks of the planner
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module escp_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  span_valid,
  input wire                  span_stall,
  input escp_pkg::in_item_t   span,
  input wire                  result_valid,
  input wire                  result_stall,
  input escp_pkg::out_item_t  result
);
  import escp_pkg::*;

  // a stalled result item holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result item after reset");

  // error items close the plan and carry no span
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_OK) |->
      result.last_result && (result.span_end == '0) && (result.span_tag == '0) &&
      !result.used_fallback)
    else $error("malformed error item");

  // no span is taken while a plan is still being emitted
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_result |-> span_stall)
    else $error("span taken during emission");

endmodule

bind edit_span_conflict_planner_core escp_checker u_escp_checker (
  .clk          (clk),
  .rst          (rst),
  .span_valid   (span_valid),
  .span_stall   (span_stall),
  .span         (span),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for edit_span_conflict_planner_core
// Drives span sets through the span channel with random gaps, predicts each
// plan in a local model of the planner and checks every result item in order.
// ----------------------------------------------------------------------------

module tb;
  import escp_pkg::*;

  localparam int SPAN_CAP      = MAX_SPANS_DEF;
  localparam int RANDOM_ITEMS  = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 3 * SPAN_CAP;

  typedef out_item_t result_list_t[$];
  typedef in_item_t  span_list_t[$];

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        span_valid = 1'b0;
  logic        span_stall;
  in_item_t    span = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;

  edit_span_conflict_planner_core u_top (
    .clk          (clk),
    .rst          (rst),
    .span_valid   (span_valid),
    .span_stall   (span_stall),
    .span         (span),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Planner model: collected spans, kept spans and the set's error state
  // --------------------------------------------------------------------------
  entry_t      held_span [SPAN_CAP];
  plan_t       kept_span [SPAN_CAP];
  int          held_count = 0;
  bit          fb_swapped = 1'b0;
  logic [1:0]  set_err = ST_OK;
  offset_t     set_err_at = '0;

  out_item_t   plan_due[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          sent_items = 0;

  // stable insertion order by start, then sweep; returns kept count, 0 on error
  function automatic int sweep_plan();
    int order [SPAN_CAP];
    int i, j, n, idx;
    offset_t es, ee;
    n = 0;
    for (i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && held_span[order[j-1]].lo > held_span[i].lo) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < held_count; i++) begin
      idx = order[i];
      es = held_span[idx].lo;
      ee = held_span[idx].hi;
      if (n > 0 && kept_span[n-1].lo < ee && es < kept_span[n-1].hi) begin
        if (held_span[idx].fb_ok && held_span[idx].fb_lo <= kept_span[n-1].lo &&
            held_span[idx].fb_hi >= kept_span[n-1].hi && held_span[idx].fb_hi >= ee &&
            (n == 1 || kept_span[n-2].hi <= held_span[idx].fb_lo)) begin
          kept_span[n-1].lo  = held_span[idx].fb_lo;
          kept_span[n-1].hi  = held_span[idx].fb_hi;
          kept_span[n-1].tag = held_span[idx].fb_tag;
          fb_swapped = 1'b1;
        end else begin
          set_err = ST_OVERLAP;
          set_err_at = es;
          return 0;
        end
      end else begin
        kept_span[n].lo  = es;
        kept_span[n].hi  = ee;
        kept_span[n].tag = held_span[idx].tag;
        n++;
      end
    end
    return n;
  endfunction

  function automatic void plan_span(input in_item_t it, output result_list_t res);
    entry_t    e;
    out_item_t r;
    int        n, k;
    res = {};
    if (held_count >= SPAN_CAP) begin
      if (set_err != ST_TOO_MANY) begin
        set_err = ST_TOO_MANY;
        set_err_at = it.primary_start;
      end
    end else begin
      e.lo     = it.primary_start;
      e.hi     = it.primary_end;
      e.tag    = it.primary_tag;
      e.fb_ok  = it.fallback_usable;
      e.fb_lo  = it.fallback_start;
      e.fb_hi  = it.fallback_end;
      e.fb_tag = it.fallback_tag;
      if (!it.primary_resolved) begin
        if (!it.fallback_usable) begin
          if (set_err == ST_OK) begin
            set_err = ST_MISSING;
            set_err_at = it.primary_start;
          end
        end else begin
          e.lo = it.fallback_start;
          e.hi = it.fallback_end;
          e.tag = it.fallback_tag;
          e.fb_ok = 1'b0;
          fb_swapped = 1'b1;
        end
      end
      held_span[held_count] = e;
      held_count++;
    end
    if (!it.last_span) return;
    n = 0;
    if (set_err == ST_OK) n = sweep_plan();
    if (set_err != ST_OK || n == 0) begin
      r = '0;
      r.span_start  = set_err_at;
      r.status      = (set_err != ST_OK) ? set_err : ST_OVERLAP;
      r.last_result = 1'b1;
      res.push_back(r);
    end else begin
      for (k = 0; k < n; k++) begin
        r.span_start    = kept_span[k].lo;
        r.span_end      = kept_span[k].hi;
        r.span_tag      = kept_span[k].tag;
        r.used_fallback = fb_swapped;
        r.status        = ST_OK;
        r.last_result   = (k + 1 == n);
        res.push_back(r);
      end
    end
    held_count = 0;
    fb_swapped = 1'b0;
    set_err = ST_OK;
    set_err_at = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t head;
    if (!rst && result_valid && !result_stall) begin
      if (plan_due.size() == 0) begin
        $error("result item with nothing pending: %h", result);
        fail_count++;
      end else begin
        head = plan_due.pop_front();
        check_field("span_start",    head.span_start,    result.span_start);
        check_field("span_end",      head.span_end,      result.span_end);
        check_field("span_tag",      head.span_tag,      result.span_tag);
        check_field("used_fallback", head.used_fallback, result.used_fallback);
        check_field("status",        head.status,        result.status);
        check_field("last_result",   head.last_result,   result.last_result);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((span_valid && !span_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver back-pressure: quiet stretches, short flicker, the odd long stall
  initial begin
    int r, len;
    bit hold;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        hold = 1'b0;
        len = $urandom_range(20, 120);
      end else if (r < 90) begin
        hold = $urandom_range(0, 1);
        len = $urandom_range(1, 4);
      end else begin
        hold = 1'b1;
        len = $urandom_range(10, 40);
      end
      result_stall <= hold;
      repeat (len) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic in_item_t mk(input offset_t ps, input offset_t pe, input bit pres,
                                  input tag_t ptag, input bit fok, input offset_t fs,
                                  input offset_t fe, input tag_t ftag, input bit last);
    in_item_t it;
    it.primary_start    = ps;
    it.primary_end      = pe;
    it.primary_resolved = pres;
    it.primary_tag      = ptag;
    it.fallback_usable  = fok;
    it.fallback_start   = fs;
    it.fallback_end     = fe;
    it.fallback_tag     = ftag;
    it.last_span        = last;
    return it;
  endfunction

  function automatic out_item_t want_of(input offset_t s, input offset_t e, input tag_t tag,
                                        input bit fb, input logic [1:0] st);
    out_item_t r;
    r.span_start    = s;
    r.span_end      = e;
    r.span_tag      = tag;
    r.used_fallback = fb;
    r.status        = st;
    r.last_result   = 1'b1;
    return r;
  endfunction

  function automatic in_item_t rand_noise();
    in_item_t it;
    it.primary_start    = $urandom;
    it.primary_end      = $urandom;
    it.primary_resolved = $urandom_range(0, 1);
    it.primary_tag      = $urandom;
    it.fallback_usable  = $urandom_range(0, 1);
    it.fallback_start   = $urandom;
    it.fallback_end     = $urandom;
    it.fallback_tag     = $urandom;
    it.last_span        = 1'b0;
    return it;
  endfunction

  task automatic send_span(input in_item_t it, input bit pinned, input out_item_t want);
    result_list_t fresh;
    span <= it;
    span_valid <= 1'b1;
    do @(posedge clk); while (span_stall);
    sent_items++;
    plan_span(it, fresh);
    if (pinned) begin
      plan_due.push_back(want);
    end else begin
      foreach (fresh[i]) plan_due.push_back(fresh[i]);
    end
  endtask

  task automatic idle_gap(input bit steady);
    int r, g;
    r = $urandom_range(0, 99);
    g = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (!steady && g > 0) begin
      span_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    span_valid <= 1'b0;
    do @(posedge clk); while (plan_due.size() != 0);
  endtask

  // well-formed sets sit in 100-byte slots; a companion overlaps its slot and
  // carries a fallback that usually encloses both
  function automatic void build_set(input int n, input bit noisy, output span_list_t q);
    in_item_t it, c;
    offset_t  origin, base;
    int       slot, j, k;
    q = {};
    origin = $urandom_range(100, 32'hFFFF_0000);
    slot = 0;
    while (q.size() < n) begin
      it = rand_noise();
      if (!noisy) begin
        base = origin + slot * 100;
        it.primary_resolved = 1'b1;
        it.primary_start = base + 10;
        it.primary_end = ($urandom_range(0, 5) == 0) ? base + 10 + $urandom_range(0, 110)
                                                      : base + 50;
        if ($urandom_range(0, 7) == 0) begin
          it.fallback_start = it.primary_start;
          it.fallback_end = it.primary_end;
          it.primary_start = $urandom;
          it.primary_end = $urandom;
          it.primary_resolved = 1'b0;
          it.fallback_usable = 1'b1;
        end
        q.push_back(it);
        if (q.size() + 1 < n && $urandom_range(0, 3) == 0) begin
          c = rand_noise();
          c.primary_resolved = 1'b1;
          c.primary_start = base + 30;
          c.primary_end = base + 70;
          c.fallback_usable = 1'b1;
          c.fallback_start = base + 5;
          c.fallback_end = base + 90;
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
              0: c.fallback_start = base + 15;
              1: c.fallback_end = base + 60;
              default: c.fallback_start = base - 60;
            endcase
          end
          q.push_back(c);
        end
        slot++;
      end else begin
        q.push_back(it);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, q.size() - 1);
      q[k].primary_resolved = 1'b0;
      q[k].fallback_usable = 1'b0;
    end
    for (j = q.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      it = q[j];
      q[j] = q[k];
      q[k] = it;
    end
    foreach (q[i]) q[i].last_span = 1'b0;
    q[q.size() - 1].last_span = 1'b1;
  endfunction

  initial begin
    dir_row_t   dir_rows[$];
    span_list_t set_q;
    int         set_no, n;
    bit         steady;

    // single spans at the extremes, then the special cases
    dir_rows.push_back('{mk(32'h0, 32'hFFFF_FFFF, 1, 16'hFFFF, 0, 32'h0, 32'h0, 16'h0, 1),
                         1'b1, want_of(32'h0, 32'hFFFF_FFFF, 16'hFFFF, 0, ST_OK)});
    dir_rows.push_back('{mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'h0, 1, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 16'hFFFF, 1),
                         1'b1, want_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 0, ST_OK)});
    dir_rows.push_back('{mk(32'h1234, 32'h5678, 0, 16'h11, 0, 32'h9, 32'h9, 16'h22, 1),
                         1'b1, want_of(32'h1234, 32'h0, 16'h0, 0, ST_MISSING)});
    dir_rows.push_back('{mk(32'h5, 32'h3, 0, 16'h1, 1, 32'd100, 32'd200, 16'hABCD, 1),
                         1'b1, want_of(32'd100, 32'd200, 16'hABCD, 1, ST_OK)});
    // overlap with no fallback
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h1, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd15, 32'd25, 1, 16'h2, 0, 32'd5, 32'd30, 16'h9, 1),
                         1'b1, want_of(32'd15, 32'h0, 16'h0, 0, ST_OVERLAP)});
    // overlap settled by an enclosing fallback
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h1, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd15, 32'd25, 1, 16'h2, 1, 32'd5, 32'd30, 16'h9, 1),
                         1'b1, want_of(32'd5, 32'd30, 16'h9, 1, ST_OK)});
    // fallback would cut into the span kept before
    dir_rows.push_back('{mk(32'd0, 32'd10, 1, 16'h1, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h2, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd15, 32'd25, 1, 16'h3, 1, 32'd5, 32'd30, 16'h9, 1),
                         1'b1, want_of(32'd15, 32'h0, 16'h0, 0, ST_OVERLAP)});
    // out of order arrival, equal starts kept in arrival order
    dir_rows.push_back('{mk(32'd300, 32'd400, 1, 16'h3, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd100, 32'd200, 1, 16'h4, 1, 32'd0, 32'd999, 16'h7, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd100, 32'd100, 1, 16'h5, 0, 32'h0, 32'h0, 16'h0, 1), 1'b0, '0});
    // first of several missing spans is reported
    dir_rows.push_back('{mk(32'h77, 32'h0, 0, 16'h1, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'h88, 32'h0, 0, 16'h2, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h3, 0, 32'h0, 32'h0, 16'h0, 1),
                         1'b1, want_of(32'h77, 32'h0, 16'h0, 0, ST_MISSING)});
    // fallback too short for the current span
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h1, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd15, 32'd40, 1, 16'h2, 1, 32'd5, 32'd30, 16'h9, 1), 1'b0, '0});
    // fallback starting after the kept span
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h1, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd15, 32'd25, 1, 16'h2, 1, 32'd12, 32'd30, 16'h9, 1), 1'b0, '0});
    // touching spans do not overlap
    dir_rows.push_back('{mk(32'd0, 32'd10, 1, 16'hFFFF, 0, 32'h0, 32'h0, 16'h0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(32'd10, 32'd20, 1, 16'h0, 0, 32'h0, 32'h0, 16'h0, 1), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_span(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);
      idle_gap(1'b0);
    end
    drain_results();

    // the first two random sets fill the store exactly and then overflow it
    set_no = 0;
    while (sent_items < dir_rows.size() + RANDOM_ITEMS) begin
      if (set_no == 0) n = SPAN_CAP;
      else if (set_no == 1) n = SPAN_CAP + 2;
      else if ($urandom_range(0, 29) == 0) n = $urandom_range(SPAN_CAP - 1, SPAN_CAP + 2);
      else n = $urandom_range(1, 10);
      build_set(n, $urandom_range(0, 4) == 0, set_q);
      steady = ($urandom_range(0, 3) == 0);
      foreach (set_q[i]) begin
        send_span(set_q[i], 1'b0, '0);
        idle_gap(steady);
      end
      if ($urandom_range(0, 7) == 0) drain_results();
      set_no++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && plan_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
